### design/tro_pkg.sv
// Package: types, widths and register indexes for the triangle/rectangle overlap test.
`default_nettype none
package tro_pkg;
    localparam int CoordBits = 16;
    localparam int CfgIdxBits = 3;
    localparam int WideBits = 2 * CoordBits + 8;

    typedef enum logic [CfgIdxBits-1:0] {
        REG_AX = 3'd0, REG_AY = 3'd1, REG_BX = 3'd2,
        REG_BY = 3'd3, REG_CX = 3'd4, REG_CY = 3'd5
    } t_reg_idx;

    // Triangle held in configuration.
    typedef struct packed {
        logic signed [CoordBits-1:0] ax, ay, bx, by, cx, cy;
    } t_tri;

    // Rectangle as corner coordinates, two bits wider than the input fields.
    typedef struct packed {
        logic signed [CoordBits+1:0] l, t, r, b;
    } t_rect;

    typedef struct packed {
        logic signed [CoordBits-1:0] rect_left;
        logic signed [CoordBits-1:0] rect_top;
        logic        [CoordBits-1:0] rect_width;
        logic        [CoordBits-1:0] rect_height;
    } t_query;
endpackage
`default_nettype wire

### design/tro_if.sv
// Valid/ready stream interfaces for queries and results.
`default_nettype none
interface tro_query_if;
    logic            valid;
    logic            ready;
    tro_pkg::t_query data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tro_result_if;
    logic valid;
    logic ready;
    logic overlaps;
    modport source (output valid, output overlaps, input ready);
    modport sink   (input valid, input overlaps, output ready);
endinterface
`default_nettype wire

### design/tro_edge.sv
// One triangle edge: three pipeline stages of crossing tests against the rectangle.
`default_nettype none
module tro_edge (
    input  wire logic                 i_clk,
    input  wire logic [2:0]           i_en,
    input  wire logic signed [tro_pkg::CoordBits-1:0] i_x1,
    input  wire logic signed [tro_pkg::CoordBits-1:0] i_y1,
    input  wire logic signed [tro_pkg::CoordBits-1:0] i_x2,
    input  wire logic signed [tro_pkg::CoordBits-1:0] i_y2,
    input  wire tro_pkg::t_rect       i_rect,
    output logic                      o_hit
);
    localparam int CB = tro_pkg::CoordBits;
    localparam int W  = tro_pkg::WideBits;

    // Stage 1: differences and trivial rejects.
    logic signed [CB+2:0] r_dx, r_dy, r_ex, r_ey;
    logic signed [CB+2:0] r_lx, r_rx, r_ty, r_by;
    logic r_rej, r_vert, r_horz;
    logic signed [CB+2:0] n_dx, n_dy;
    logic signed [CB+2:0] x1w, y1w, x2w, y2w, lw, tw, rw, bw;

    always_comb begin
        x1w = (CB+3)'(i_x1); y1w = (CB+3)'(i_y1);
        x2w = (CB+3)'(i_x2); y2w = (CB+3)'(i_y2);
        lw = (CB+3)'(i_rect.l); tw = (CB+3)'(i_rect.t);
        rw = (CB+3)'(i_rect.r); bw = (CB+3)'(i_rect.b);
        n_dx = x2w - x1w;
        n_dy = y2w - y1w;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rej <= (x1w <= lw && x2w <= lw) || (y1w <= tw && y2w <= tw) ||
                     (x1w >= rw && x2w >= rw) || (y1w >= bw && y2w >= bw);
            r_vert <= (n_dx == '0);
            r_horz <= (n_dy == '0);
            r_dx <= n_dx[CB+2] ? -n_dx : n_dx;
            r_dy <= n_dx[CB+2] ? -n_dy : n_dy;
            r_ey <= n_dy[CB+2] ? -n_dy : n_dy;
            r_ex <= n_dy[CB+2] ? -n_dx : n_dx;
            r_lx <= lw - x1w; r_rx <= rw - x1w;
            r_ty <= tw - y1w; r_by <= bw - y1w;
        end
    end

    // Stage 2: eight products.
    logic signed [W-1:0] r_p [8];
    logic r_rej2;
    logic r_horz2;
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_p[0] <= W'(r_ty * r_dx);
            r_p[1] <= W'(r_by * r_dx);
            r_p[2] <= W'(r_dy * r_lx);
            r_p[3] <= W'(r_dy * r_rx);
            r_p[4] <= W'(r_lx * r_ey);
            r_p[5] <= W'(r_rx * r_ey);
            r_p[6] <= W'(r_ty * r_ex);
            r_p[7] <= W'(r_by * r_ex);
            r_rej2 <= r_rej || r_vert;
            r_horz2 <= r_horz;
        end
    end

    // Stage 3: compares.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_hit <= !r_rej2 && (
                (r_p[0] < r_p[2] && r_p[2] < r_p[1]) ||
                (r_p[0] < r_p[3] && r_p[3] < r_p[1]) ||
                (!r_horz2 && r_p[4] < r_p[6] && r_p[6] < r_p[5]) ||
                (!r_horz2 && r_p[4] < r_p[7] && r_p[7] < r_p[5]));
        end
    end
endmodule
`default_nettype wire

### design/tro_center.sv
// Bounding box and center-in-triangle tests over three pipeline stages.
`default_nettype none
module tro_center (
    input  wire logic          i_clk,
    input  wire logic [2:0]    i_en,
    input  wire tro_pkg::t_tri i_tri,
    input  wire tro_pkg::t_rect i_rect,
    input  wire logic signed [tro_pkg::CoordBits+1:0] i_px,
    input  wire logic signed [tro_pkg::CoordBits+1:0] i_py,
    output logic               o_box,
    output logic               o_inside
);
    localparam int CB = tro_pkg::CoordBits;
    localparam int W  = tro_pkg::WideBits;

    function automatic logic signed [CB+1:0] mn3(input logic signed [CB+1:0] a,
        input logic signed [CB+1:0] b, input logic signed [CB+1:0] c);
        logic signed [CB+1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction
    function automatic logic signed [CB+1:0] mx3(input logic signed [CB+1:0] a,
        input logic signed [CB+1:0] b, input logic signed [CB+1:0] c);
        logic signed [CB+1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    logic signed [CB+1:0] ax, ay, bx, by, cx, cy;
    assign ax = (CB+2)'(i_tri.ax); assign ay = (CB+2)'(i_tri.ay);
    assign bx = (CB+2)'(i_tri.bx); assign by = (CB+2)'(i_tri.by);
    assign cx = (CB+2)'(i_tri.cx); assign cy = (CB+2)'(i_tri.cy);

    // Stage 1: box test and differences in doubled coordinates.
    logic r_box1;
    logic signed [CB+3:0] r_d [12];
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_box1 <= mn3(ax, bx, cx) < i_rect.r && mx3(ax, bx, cx) > i_rect.l &&
                      mn3(ay, by, cy) < i_rect.b && mx3(ay, by, cy) > i_rect.t;
            r_d[0]  <= (CB+4)'(i_px) - ((CB+4)'(bx) <<< 1);
            r_d[1]  <= ((CB+4)'(ay) - (CB+4)'(by)) <<< 1;
            r_d[2]  <= ((CB+4)'(ax) - (CB+4)'(bx)) <<< 1;
            r_d[3]  <= (CB+4)'(i_py) - ((CB+4)'(by) <<< 1);
            r_d[4]  <= (CB+4)'(i_px) - ((CB+4)'(cx) <<< 1);
            r_d[5]  <= ((CB+4)'(by) - (CB+4)'(cy)) <<< 1;
            r_d[6]  <= ((CB+4)'(bx) - (CB+4)'(cx)) <<< 1;
            r_d[7]  <= (CB+4)'(i_py) - ((CB+4)'(cy) <<< 1);
            r_d[8]  <= (CB+4)'(i_px) - ((CB+4)'(ax) <<< 1);
            r_d[9]  <= ((CB+4)'(cy) - (CB+4)'(ay)) <<< 1;
            r_d[10] <= ((CB+4)'(cx) - (CB+4)'(ax)) <<< 1;
            r_d[11] <= (CB+4)'(i_py) - ((CB+4)'(ay) <<< 1);
        end
    end

    // Stage 2: six products.
    logic r_box2;
    logic signed [W-1:0] r_m [6];
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_box2 <= r_box1;
            for (int k = 0; k < 3; k++) begin
                r_m[2*k]   <= W'(r_d[4*k] * r_d[4*k+1]);
                r_m[2*k+1] <= W'(r_d[4*k+2] * r_d[4*k+3]);
            end
        end
    end

    // Stage 3: cross product signs.
    logic s1, s2, s3;
    assign s1 = (r_m[0] - r_m[1]) < 0;
    assign s2 = (r_m[2] - r_m[3]) < 0;
    assign s3 = (r_m[4] - r_m[5]) < 0;
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_box    <= r_box2;
            o_inside <= (s1 == s2) && (s2 == s3);
        end
    end
endmodule
`default_nettype wire

### design/triangle_rect_overlap_test.sv
// Top level of the triangle/rectangle overlap test.
// Usage: write the six vertex registers through i_cfg_we / i_cfg_idx /
// i_cfg_data while no item is in flight; indexes above five are ignored.
// Queries enter on i_query (left, top, width, height) and one result item
// per query leaves on o_result (overlaps).
// Pipeline: the accepting edge loads the input stage, and three compute
// stages follow (differences, products, compares); a result then waits in
// the output register until taken.
// Throughput: one item per cycle while the receiver takes results, through the
// pipelined multipliers of the center unit and the edge units u_ab, u_bc and u_ca.
// Reset clears the vertex registers to zero and all valid bits.
// When the receiver stalls, the full stages hold; nothing is lost or
// repeated, and a query is still accepted where a stage ahead has a gap.
`default_nettype none
module triangle_rect_overlap_test (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tro_pkg::CfgIdxBits-1:0]     i_cfg_idx,
    input  wire logic [tro_pkg::CoordBits-1:0]      i_cfg_data,
    tro_query_if.sink                               i_query,
    tro_result_if.source                            o_result
);
    localparam int CB = tro_pkg::CoordBits;

    tro_pkg::t_tri r_tri;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tro_pkg::REG_AX: r_tri.ax <= i_cfg_data;
                tro_pkg::REG_AY: r_tri.ay <= i_cfg_data;
                tro_pkg::REG_BX: r_tri.bx <= i_cfg_data;
                tro_pkg::REG_BY: r_tri.by <= i_cfg_data;
                tro_pkg::REG_CX: r_tri.cx <= i_cfg_data;
                tro_pkg::REG_CY: r_tri.cy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits: input stage, three compute stages (the last is the output).
    logic [3:0] r_vld;
    logic [3:0] stg_en;
    always_comb begin
        stg_en[3] = !r_vld[3] || o_result.ready;
        for (int k = 2; k >= 0; k--) stg_en[k] = !r_vld[k] || stg_en[k+1];
    end
    assign i_query.ready = stg_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) r_vld[0] <= i_query.valid;
            for (int k = 1; k < 4; k++) if (stg_en[k]) r_vld[k] <= r_vld[k-1];
        end
    end

    // Input stage: rectangle corners and doubled center.
    tro_pkg::t_rect r_rect;
    logic signed [CB+1:0] r_px, r_py;
    always_ff @(posedge i_clk) begin
        if (stg_en[0] && i_query.valid) begin
            r_rect.l <= (CB+2)'(i_query.data.rect_left);
            r_rect.t <= (CB+2)'(i_query.data.rect_top);
            r_rect.r <= (CB+2)'(i_query.data.rect_left) +
                        $signed({2'b00, i_query.data.rect_width});
            r_rect.b <= (CB+2)'(i_query.data.rect_top) +
                        $signed({2'b00, i_query.data.rect_height});
            r_px <= ((CB+2)'(i_query.data.rect_left) <<< 1) +
                    $signed({2'b00, i_query.data.rect_width});
            r_py <= ((CB+2)'(i_query.data.rect_top) <<< 1) +
                    $signed({2'b00, i_query.data.rect_height});
        end
    end

    logic box, ctr_hit, h_ab, h_bc, h_ca;
    tro_center u_center (
        .i_clk(i_clk), .i_en(stg_en[3:1]), .i_tri(r_tri), .i_rect(r_rect),
        .i_px(r_px), .i_py(r_py), .o_box(box), .o_inside(ctr_hit)
    );
    tro_edge u_ab (
        .i_clk(i_clk), .i_en(stg_en[3:1]), .i_x1(r_tri.ax), .i_y1(r_tri.ay),
        .i_x2(r_tri.bx), .i_y2(r_tri.by), .i_rect(r_rect), .o_hit(h_ab)
    );
    tro_edge u_bc (
        .i_clk(i_clk), .i_en(stg_en[3:1]), .i_x1(r_tri.bx), .i_y1(r_tri.by),
        .i_x2(r_tri.cx), .i_y2(r_tri.cy), .i_rect(r_rect), .o_hit(h_bc)
    );
    tro_edge u_ca (
        .i_clk(i_clk), .i_en(stg_en[3:1]), .i_x1(r_tri.cx), .i_y1(r_tri.cy),
        .i_x2(r_tri.ax), .i_y2(r_tri.ay), .i_rect(r_rect), .o_hit(h_ca)
    );

    assign o_result.valid    = r_vld[3];
    assign o_result.overlaps = box && (ctr_hit || h_ab || h_bc || h_ca);
endmodule
`default_nettype wire
